@@ hdl/psl_pkg.sv @@
package psl_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CAPACITY_MAX = 1024;
  // wide enough for any position or length up to the largest capacity
  localparam int POS_W = $clog2(CAPACITY_MAX + 1);
  // match bits examined per scan cycle
  localparam int CHUNK = 8;
  localparam int ENC_W = $clog2(CHUNK);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_SEARCH = 2'd3
  } func_e;

  localparam logic [2:0] KIND_TURQUOISE = 3'd0;
  localparam logic [2:0] KIND_CORAL     = 3'd1;
  localparam logic [2:0] KIND_GOLD      = 3'd2;
  localparam logic [2:0] KIND_COPPER    = 3'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    func_e       func;
    logic [2:0]  bead_kind;
    logic [6:0]  slot;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        found;
    logic [5:0]  found_index;
    logic [6:0]  count;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             shift_r;
    logic             shift_l;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len;
    logic [1:0]       sym;
    logic             kind_ok;
  } cell_ctl_t;

endpackage

@@ hdl/psl_cell.sv @@
module psl_cell
  import psl_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic [1:0] left_sym,
  input  logic [1:0] right_sym,
  output logic [1:0] sym,
  output logic       match
);

  localparam logic [POS_W-1:0] MY = POS_W'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.shift_r) begin
      if (MY == ctl.pos) begin
        sym <= ctl.sym;
      end else if (MY > ctl.pos) begin
        sym <= left_sym;
      end
    end else if (ctl.shift_l && MY >= ctl.pos) begin
      sym <= right_sym;
    end
  end

  assign match = (MY < ctl.len) && ctl.kind_ok && (sym == ctl.sym);

endmodule

@@ hdl/psl_scan.sv @@
module psl_scan
  import psl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [CAPACITY-1:0]          match_vec,
  output logic                         done,
  output logic                         found,
  output logic [$clog2(CAPACITY)-1:0]  idx
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int NCH   = (CAPACITY + CHUNK - 1) / CHUNK;
  localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int VW    = NCH * CHUNK;

  logic [VW-1:0]    vec;
  logic [CH_W-1:0]  chunk;
  logic             busy;
  logic [CHUNK-1:0] low;
  logic [ENC_W-1:0] enc;
  logic             last;

  assign low  = vec[CHUNK-1:0];
  assign last = (chunk == CH_W'(NCH - 1));

  // lowest set bit of the current chunk wins
  always_comb begin
    enc = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (low[j]) begin
        enc = ENC_W'(j);
      end
    end
  end

  assign found = busy && (|low);
  assign done  = busy && ((|low) || last);
  assign idx   = IDX_W'({chunk, enc});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      chunk <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      chunk <= '0;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
      end else begin
        chunk <= chunk + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vec <= VW'(match_vec);
    end else if (busy) begin
      vec <= vec >> CHUNK;
    end
  end

endmodule

@@ hdl/positional_symbol_list_unit.sv @@
// Ordered list of up to CAPACITY two-bit material symbols, held in a row of
// cells; on insert and delete the cells from the slot onward shift by one.
// Request channel req_valid/req_ready carries func, bead_kind and slot; every
// accepted request yields exactly one beat on rsp_valid/rsp_ready with status,
// found, found_index and the list length after the request.
// Append, insert and delete update the cells in the cycle the request is
// taken; the result passes through the pending stage and then the output
// register before rsp_valid rises, and a new request may follow in every
// cycle while the receiver keeps up.
// Search latches the per-cell match bits and walks them eight per cycle,
// chunk by chunk from index 0, ending early at the first hit; no request is
// taken meanwhile.
// Results pass through a pending stage and an output register, so a stalled
// receiver does not block the next request until both are occupied.
// Reset empties the list and drops any pending or presented result; the
// symbol cells themselves are not cleared, only the length is.
module positional_symbol_list_unit
  import psl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  length, length_next;
  logic              pend_valid;
  rsp_t              pend;
  logic              move;
  logic              fire;
  logic              kind_ok;
  logic              full;
  logic [POS_W-1:0]  len_p, slot_p, ins_pos;
  logic              put_ok, del_ok;
  logic              is_put, is_del, is_search;
  cell_ctl_t         ctl;
  logic [1:0]        cell_sym [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic              scan_done, scan_found;
  logic [IDX_W-1:0]  scan_idx;

  assign fire      = req_valid && req_ready;
  assign kind_ok   = (req.bead_kind <= KIND_COPPER);
  assign len_p     = POS_W'(length);
  assign slot_p    = POS_W'(req.slot);
  assign full      = (length == CNT_W'(CAPACITY));
  assign is_put    = (req.func == OP_APPEND) || (req.func == OP_INSERT);
  assign is_del    = (req.func == OP_DELETE);
  assign is_search = (req.func == OP_SEARCH);

  always_comb begin
    if (req.func == OP_APPEND || length == '0) begin
      ins_pos = len_p;
    end else begin
      ins_pos = slot_p;
    end
  end

  assign put_ok = kind_ok && !full && (ins_pos <= len_p);
  assign del_ok = (slot_p < len_p);

  always_comb begin
    ctl.shift_r = fire && is_put && put_ok;
    ctl.shift_l = fire && is_del && del_ok;
    ctl.pos     = is_del ? slot_p : ins_pos;
    ctl.len     = len_p;
    ctl.sym     = req.bead_kind[1:0];
    ctl.kind_ok = kind_ok;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [1:0] left_sym, right_sym;
    if (i == 0) begin : g_head
      assign left_sym = ctl.sym;
    end else begin : g_mid
      assign left_sym = cell_sym[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_sym = '0;
    end else begin : g_body
      assign right_sym = cell_sym[i+1];
    end
    psl_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_sym  (left_sym),
      .right_sym (right_sym),
      .sym       (cell_sym[i]),
      .match     (match_vec[i])
    );
  end

  psl_scan #(.CAPACITY(CAPACITY)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && is_search),
    .match_vec (match_vec),
    .done      (scan_done),
    .found     (scan_found),
    .idx       (scan_idx)
  );

  always_comb begin
    length_next = length;
    if (ctl.shift_r) begin
      length_next = length + CNT_W'(1);
    end else if (ctl.shift_l) begin
      length_next = length - CNT_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (fire && is_search) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign move      = pend_valid && (!rsp_valid || rsp_ready);
  assign req_ready = (state == S_IDLE) && (!pend_valid || move);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      length     <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      if ((fire && !is_search) || scan_done) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_search) begin
      pend.status      <= (ctl.shift_r || ctl.shift_l) ? STATUS_OK : STATUS_FAIL;
      pend.found       <= 1'b0;
      pend.found_index <= '0;
      pend.count       <= 7'(length_next);
    end else if (scan_done) begin
      pend.status      <= scan_found ? STATUS_OK : STATUS_FAIL;
      pend.found       <= scan_found;
      pend.found_index <= scan_found ? 6'(scan_idx) : '0;
      pend.count       <= 7'(length);
    end
    if (move) begin
      rsp <= pend;
    end
  end

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  a_scan_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !req_ready)
    else $error("request taken during search");

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> state == S_SCAN)
    else $error("search finished outside scan state");

  a_result_queued: assert property (@(posedge clk) disable iff (rst)
    fire && !is_search |=> pend_valid)
    else $error("result of an update request lost");

endmodule

@@ tb/positional_symbol_list_unit_test.sv @@
`timescale 1ns / 100ps

module positional_symbol_list_unit_test
  import psl_pkg::*;
();

  localparam int LONG_HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  positional_symbol_list_unit dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // list contents as the block should hold them
  logic [1:0] beads [0:CAPACITY_DEF-1];
  int bead_count = 0;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  rsp_t want_rsp;
  int mismatch_count = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int long_hold_asked = 0;
  int long_hold_taken = 0;
  int long_hold_left = 0;

  // Apply one request to the list and return the beat it should produce.
  function automatic rsp_t list_apply(req_t r);
    rsp_t res;
    int pos;
    res = '0;
    res.status = STATUS_FAIL;
    case (r.func) inside
      OP_APPEND, OP_INSERT: begin
        // append, and insert into an empty list, both land at the tail
        pos = (r.func == OP_APPEND || bead_count == 0) ? bead_count : int'(r.slot);
        if (r.bead_kind <= KIND_COPPER && bead_count < CAPACITY_DEF && pos <= bead_count) begin
          for (int i = bead_count; i > pos; i--) beads[i] = beads[i-1];
          beads[pos] = r.bead_kind[1:0];
          bead_count++;
          res.status = STATUS_OK;
        end
      end
      OP_DELETE: begin
        if (int'(r.slot) < bead_count) begin
          for (int i = int'(r.slot); i + 1 < bead_count; i++) beads[i] = beads[i+1];
          bead_count--;
          res.status = STATUS_OK;
        end
      end
      default: begin
        if (r.bead_kind <= KIND_COPPER) begin
          for (int i = 0; i < bead_count; i++) begin
            if (beads[i] == r.bead_kind[1:0]) begin
              res.found = 1'b1;
              res.found_index = 6'(i);
              break;
            end
          end
        end
        res.status = res.found ? STATUS_OK : STATUS_FAIL;
      end
    endcase
    res.count = 7'(bead_count);
    return res;
  endfunction

  function automatic logic [2:0] pick_kind(logic [2:0] pref);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return pref;
    if (roll < 85) return 3'($urandom_range(0, 3));
    return 3'($urandom_range(4, 7));
  endfunction

  function automatic req_t pick_request(int w_app, int w_ins, int w_del,
                                        logic [2:0] pref, int slot_hi);
    req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < w_app) r.func = OP_APPEND;
    else if (roll < w_app + w_ins) r.func = OP_INSERT;
    else if (roll < w_app + w_ins + w_del) r.func = OP_DELETE;
    else r.func = OP_SEARCH;
    r.bead_kind = pick_kind(pref);
    if ($urandom_range(0, 4) != 0) r.slot = 7'($urandom_range(0, slot_hi));
    else r.slot = 7'($urandom_range(0, 127));
    return r;
  endfunction

  task automatic push_req(func_e f, logic [2:0] k, logic [6:0] s);
    req_t r;
    r.func = f;
    r.bead_kind = k;
    r.slot = s;
    pending_reqs.push_back(r);
  endtask

  // Wait for the previous batch to go out, then queue a random batch.
  task automatic queue_phase(int w_app, int w_ins, int w_del, logic [2:0] pref,
                             int slot_hi, int send_pct, int recv_pct);
    do @(negedge clk); while (pending_reqs.size() != 0);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (PHASE_ITEMS) pending_reqs.push_back(pick_request(w_app, w_ins, w_del, pref, slot_hi));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
  endtask

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Request driver: predict on every accepted beat, then offer the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_valid && req_ready) expected_rsps.push_back(list_apply(req));
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap <= $urandom_range(0, 9);
          req_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response side back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_gap <= 0;
    end else if (long_hold_taken != long_hold_asked) begin
      long_hold_taken <= long_hold_asked;
      long_hold_left <= LONG_HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      rsp_ready <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap <= $urandom_range(0, 9);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0d ns: unexpected beat, expected none, actual %p", $time, rsp);
        mismatch_count++;
      end else begin
        want_rsp = expected_rsps.pop_front();
        compare_field("status", want_rsp.status, rsp.status);
        compare_field("found", want_rsp.found, rsp.found);
        compare_field("found_index", want_rsp.found_index, rsp.found_index);
        compare_field("count", want_rsp.count, rsp.count);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 25;
    recv_idle_pct = 25;

    // empty list corners
    push_req(OP_SEARCH, KIND_TURQUOISE, 7'd0);
    push_req(OP_DELETE, KIND_TURQUOISE, 7'd0);
    push_req(OP_INSERT, KIND_CORAL, 7'd100);
    // unknown material, then two valid beads
    push_req(OP_APPEND, 3'd7, 7'd0);
    push_req(OP_INSERT, 3'd4, 7'd0);
    push_req(OP_APPEND, KIND_GOLD, 7'd127);
    push_req(OP_INSERT, KIND_COPPER, 7'd0);
    // slot at the tail, then past it
    push_req(OP_INSERT, KIND_TURQUOISE, 7'd3);
    push_req(OP_INSERT, KIND_TURQUOISE, 7'd5);
    push_req(OP_INSERT, KIND_GOLD, 7'd127);
    push_req(OP_SEARCH, KIND_GOLD, 7'd0);
    push_req(OP_SEARCH, 3'd5, 7'd0);
    push_req(OP_SEARCH, KIND_COPPER, 7'd0);
    push_req(OP_DELETE, KIND_TURQUOISE, 7'd4);
    push_req(OP_DELETE, 3'd6, 7'd127);
    push_req(OP_DELETE, KIND_TURQUOISE, 7'd0);
    push_req(OP_DELETE, KIND_TURQUOISE, 7'd2);
    push_req(OP_INSERT, KIND_COPPER, 7'd1);
    push_req(OP_SEARCH, KIND_TURQUOISE, 7'd0);
    push_req(OP_SEARCH, 3'd7, 7'd64);

    // fill mostly with one material so searches for the rest hit deep
    queue_phase(45, 25, 10, KIND_TURQUOISE, 64, 20, 20);
    wait_drained();
    // stay near full, and hold off the receiver long enough to stall requests
    queue_phase(35, 25, 15, KIND_CORAL, 64, 0, 0);
    long_hold_asked++;
    // drain from the head
    queue_phase(5, 10, 60, KIND_GOLD, 6, 20, 20);
    // mixed traffic, no idling to the end
    queue_phase(25, 25, 25, KIND_COPPER, 40, 0, 0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/psl_pkg.sv
hdl/psl_cell.sv
hdl/psl_scan.sv
hdl/positional_symbol_list_unit.sv
tb/positional_symbol_list_unit_test.sv
